// ----- hdl/eth_ipv4_udp_header_parser_unit_macros.svh -----
// Assertion macros shared by the header parser RTL.
// Included by the modules that carry assertions; depends on nothing else.
`ifndef ETH_IPV4_UDP_HEADER_PARSER_UNIT_MACROS_SVH
`define ETH_IPV4_UDP_HEADER_PARSER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define EIUHP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");
`define EIUHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define EIUHP_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define EIUHP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hdl/eiuhp_pkg.sv -----
// Package for the Ethernet/IPv4/UDP header parser: constants, status codes
// and the structures passed between the parser modules. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package eiuhp_pkg;

	localparam int unsigned ETH_HDR_BYTES  = 14;
	localparam int unsigned IP_MIN_BYTES   = 20;
	localparam int unsigned UDP_HDR_BYTES  = 8;
	localparam int unsigned IPV4_VERSION   = 4;
	localparam int unsigned ETHERTYPE_POS  = 12;
	localparam int unsigned PROTOCOL_POS   = ETH_HDR_BYTES + 9;
	localparam int unsigned MIN_IHL_WORDS  = IP_MIN_BYTES / 4;
	localparam int unsigned UDP_LEN_POS    = 4;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;

	localparam int unsigned CFG_INDEX_W    = 2;
	localparam int unsigned CFG_DATA_W     = 16;
	localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_ETHERTYPE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_PROTOCOL  = 2'd1;

	typedef enum logic [3:0] {
		ST_UDP_FOUND   = 4'd0,
		ST_EMPTY       = 4'd1,
		ST_SHORT_ETH   = 4'd2,
		ST_ETHERTYPE   = 4'd3,
		ST_SHORT_IP    = 4'd4,
		ST_VERSION     = 4'd5,
		ST_PROTOCOL    = 4'd6,
		ST_IHL         = 4'd7,
		ST_OPTIONS     = 4'd8,
		ST_SHORT_UDP   = 4'd9,
		ST_UDP_LEN     = 4'd10
	} status_t;

	typedef struct packed {
		logic [15:0] ethertype;
		logic [3:0]  version;
		logic [3:0]  header_words;
		logic [7:0]  protocol;
		logic [15:0] udp_length;
	} hdr_fields_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] payload_length;
		logic [6:0]  payload_offset;
	} verdict_t;

endpackage
`default_nettype wire

// ----- hdl/eiuhp_verdict.sv -----
// Verdict logic of the header parser: applies the checks in order to the
// captured header fields and the frame length. Depends on eiuhp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module eiuhp_verdict (
	input  wire eiuhp_pkg::hdr_fields_t fields,
	input  wire logic [16:0]            frame_len,
	input  wire logic [15:0]            expected_ethertype,
	input  wire logic [7:0]             expected_protocol,
	output eiuhp_pkg::verdict_t         verdict
);

	logic [5:0]  ip_bytes;
	logic [16:0] ip_end;
	logic [16:0] udp_end;

	assign ip_bytes = {fields.header_words, 2'b00};
	assign ip_end   = 17'(eiuhp_pkg::ETH_HDR_BYTES) + {11'd0, ip_bytes};
	assign udp_end  = ip_end + 17'(eiuhp_pkg::UDP_HDR_BYTES);

	always_comb begin
		verdict.status         = eiuhp_pkg::ST_UDP_FOUND;
		verdict.payload_length = 16'd0;
		verdict.payload_offset = 7'd0;
		if (frame_len < 17'(eiuhp_pkg::ETH_HDR_BYTES)) begin
			verdict.status = eiuhp_pkg::ST_SHORT_ETH;
		end else if (fields.ethertype != expected_ethertype) begin
			verdict.status = eiuhp_pkg::ST_ETHERTYPE;
		end else if (frame_len < 17'(eiuhp_pkg::ETH_HDR_BYTES + eiuhp_pkg::IP_MIN_BYTES)) begin
			verdict.status = eiuhp_pkg::ST_SHORT_IP;
		end else if (fields.version != 4'(eiuhp_pkg::IPV4_VERSION)) begin
			verdict.status = eiuhp_pkg::ST_VERSION;
		end else if (fields.protocol != expected_protocol) begin
			verdict.status = eiuhp_pkg::ST_PROTOCOL;
		end else if (ip_bytes < 6'(eiuhp_pkg::IP_MIN_BYTES)) begin
			verdict.status = eiuhp_pkg::ST_IHL;
		end else if (ip_end > frame_len) begin
			verdict.status = eiuhp_pkg::ST_OPTIONS;
		end else if (udp_end > frame_len) begin
			verdict.status = eiuhp_pkg::ST_SHORT_UDP;
		end else if (fields.udp_length < 16'(eiuhp_pkg::UDP_HDR_BYTES)) begin
			verdict.status = eiuhp_pkg::ST_UDP_LEN;
		end else begin
			verdict.payload_length = fields.udp_length - 16'(eiuhp_pkg::UDP_HDR_BYTES);
			verdict.payload_offset = 7'(eiuhp_pkg::ETH_HDR_BYTES + eiuhp_pkg::UDP_HDR_BYTES)
				+ {1'b0, ip_bytes};
		end
	end

endmodule
`default_nettype wire

// ----- hdl/eth_ipv4_udp_header_parser_unit.sv -----
// This parser takes one frame byte per cycle, back to back, and places a
// single verdict for each frame in the result register once its last byte,
// held in the input register, can advance: the verdict is registered from
// that byte while the result register is free. The input stalls only while
// a last byte sits in the input register and the result register still holds
// a stalled verdict; all other bytes pass without wait.
// Configuration registers should be written only while no frame is in flight.
// Top level; depends on eiuhp_pkg, eiuhp_verdict and the macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "eth_ipv4_udp_header_parser_unit_macros.svh"
module eth_ipv4_udp_header_parser_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [7:0]                          data_byte,
	input  wire logic                                last_byte,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [3:0]                               status,
	output logic [15:0]                              payload_length,
	output logic [6:0]                               payload_offset,
	input  wire logic                                cfg_write_en,
	input  wire logic [eiuhp_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [eiuhp_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic [15:0] expected_ethertype_q;
	logic [7:0]  expected_protocol_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        adv_s1;
	logic        out_free;

	logic [15:0]            byte_count_q;
	eiuhp_pkg::hdr_fields_t fields_q;
	eiuhp_pkg::hdr_fields_t fields_n;
	logic [6:0]             udp_start;
	logic [15:0]            udp_len_pos;
	logic [16:0]            frame_len;
	eiuhp_pkg::verdict_t    verdict;

	logic                   out_valid_q;
	eiuhp_pkg::verdict_t    out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_ethertype_q <= eiuhp_pkg::ETHERTYPE_IPV4;
			expected_protocol_q  <= eiuhp_pkg::PROTO_UDP;
		end else if (cfg_write_en) begin
			case (cfg_index)
				eiuhp_pkg::CFG_EXPECTED_ETHERTYPE: expected_ethertype_q <= cfg_data[15:0];
				eiuhp_pkg::CFG_EXPECTED_PROTOCOL:  expected_protocol_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign adv_s1   = valid_s1 && (!last_s1 || out_free);
	assign in_stall = valid_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	assign udp_start   = 7'(eiuhp_pkg::ETH_HDR_BYTES) + {1'b0, fields_q.header_words, 2'b00};
	assign udp_len_pos = {9'd0, udp_start} + 16'(eiuhp_pkg::UDP_LEN_POS);
	assign frame_len   = {1'b0, byte_count_q} + 17'd1;

	always_comb begin
		fields_n = fields_q;
		if (byte_count_q == 16'(eiuhp_pkg::ETHERTYPE_POS)) begin
			fields_n.ethertype[15:8] = byte_s1;
		end else if (byte_count_q == 16'(eiuhp_pkg::ETHERTYPE_POS + 1)) begin
			fields_n.ethertype[7:0] = byte_s1;
		end else if (byte_count_q == 16'(eiuhp_pkg::ETH_HDR_BYTES)) begin
			fields_n.version      = byte_s1[7:4];
			fields_n.header_words = byte_s1[3:0];
		end else if (byte_count_q == 16'(eiuhp_pkg::PROTOCOL_POS)) begin
			fields_n.protocol = byte_s1;
		end
		if (fields_q.header_words >= 4'(eiuhp_pkg::MIN_IHL_WORDS)
				&& byte_count_q > 16'(eiuhp_pkg::ETH_HDR_BYTES)) begin
			if (byte_count_q == udp_len_pos) begin
				fields_n.udp_length[15:8] = byte_s1;
			end else if (byte_count_q == udp_len_pos + 16'd1) begin
				fields_n.udp_length[7:0] = byte_s1;
			end
		end
	end

	eiuhp_verdict u_verdict (
		.fields             (fields_n),
		.frame_len          (frame_len),
		.expected_ethertype (expected_ethertype_q),
		.expected_protocol  (expected_protocol_q),
		.verdict            (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= 16'd0;
			fields_q     <= '0;
		end else if (adv_s1) begin
			if (last_s1) begin
				byte_count_q <= 16'd0;
				fields_q     <= '0;
			end else begin
				fields_q <= fields_n;
				if (byte_count_q != 16'hFFFF) begin
					byte_count_q <= byte_count_q + 16'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && adv_s1 && last_s1) begin
			out_q <= verdict;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_q.status;
	assign payload_length = out_q.payload_length;
	assign payload_offset = out_q.payload_offset;

	`EIUHP_ASSERT_SAME(a_fail_zero, clk, arst_n,
		out_valid_q && out_q.status != eiuhp_pkg::ST_UDP_FOUND,
		out_q.payload_length == 16'd0 && out_q.payload_offset == 7'd0)
	`EIUHP_ASSERT_SAME(a_found_offset, clk, arst_n,
		out_valid_q && out_q.status == eiuhp_pkg::ST_UDP_FOUND,
		out_q.payload_offset >= 7'(eiuhp_pkg::ETH_HDR_BYTES + eiuhp_pkg::IP_MIN_BYTES
			+ eiuhp_pkg::UDP_HDR_BYTES))
	`EIUHP_ASSERT_SAME(a_never_empty, clk, arst_n,
		out_valid_q, out_q.status != eiuhp_pkg::ST_EMPTY)
	`EIUHP_ASSERT_NEXT(a_clear_after_last, clk, arst_n,
		adv_s1 && last_s1, byte_count_q == 16'd0 && fields_q == '0)
	`EIUHP_ASSERT_SAME(a_mid_frame_flows, clk, arst_n,
		valid_s1 && !last_s1, !in_stall)

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the Ethernet/IPv4/UDP header parser, fed frame by frame
// through a bursty byte driver. A stalling verdict monitor checks each output.
// Depends on eiuhp_pkg and eth_ipv4_udp_header_parser_unit only.
module tb;

	localparam logic [eiuhp_pkg::CFG_INDEX_W-1:0] CFG_UNMAPPED_A = 2'd2;
	localparam logic [eiuhp_pkg::CFG_INDEX_W-1:0] CFG_UNMAPPED_B = 2'd3;
	localparam int unsigned IDLE_LIMIT = 4000;

	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} frame_byte_t;

	typedef enum logic [1:0] {RX_FREE, RX_CHOPPY, RX_BURSTY} rx_pattern_t;

	logic                              clk;
	logic                              arst_n = 1'b0;
	logic                              in_valid = 1'b0;
	logic                              in_stall;
	logic [7:0]                        data_byte = 8'd0;
	logic                              last_byte = 1'b0;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic [3:0]                        status;
	logic [15:0]                       payload_length;
	logic [6:0]                        payload_offset;
	logic                              cfg_write_en = 1'b0;
	logic [eiuhp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [eiuhp_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

	// Mirror of the configuration and of the per-frame capture state.
	logic [15:0] want_ethertype = eiuhp_pkg::ETHERTYPE_IPV4;
	logic [7:0]  want_protocol = eiuhp_pkg::PROTO_UDP;
	logic [15:0] byte_cnt = '0;
	logic [15:0] seen_ethertype = '0;
	logic [3:0]  seen_version = '0;
	logic [3:0]  hdr_words = '0;
	logic [7:0]  seen_protocol = '0;
	logic [15:0] seen_udp_len = '0;

	frame_byte_t         bytes_to_send[$];
	eiuhp_pkg::verdict_t verdicts_due[$];
	logic [7:0]          frame_buf[$];
	int unsigned         bytes_queued = 0;
	int unsigned         mismatches = 0;
	int unsigned         idle_cycles = 0;

	frame_byte_t         next_byte;
	int unsigned         burst_left = 0;
	int unsigned         gap_left = 0;
	eiuhp_pkg::verdict_t due;
	rx_pattern_t         rx_pattern = RX_FREE;
	int unsigned         rx_cycle = 0;
	int unsigned         stall_left = 0;

	eth_ipv4_udp_header_parser_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.payload_length(payload_length),
		.payload_offset(payload_offset),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function void parse_byte(input logic [7:0] b, input logic fin);
		int unsigned         pos;
		int unsigned         udp_start;
		int unsigned         frame_len;
		int unsigned         ip_bytes;
		eiuhp_pkg::verdict_t v;
		pos = byte_cnt;
		udp_start = eiuhp_pkg::ETH_HDR_BYTES + 4 * hdr_words;
		if (pos == eiuhp_pkg::ETHERTYPE_POS) begin
			seen_ethertype[15:8] = b;
		end else if (pos == eiuhp_pkg::ETHERTYPE_POS + 1) begin
			seen_ethertype[7:0] = b;
		end else if (pos == eiuhp_pkg::ETH_HDR_BYTES) begin
			seen_version = b[7:4];
			hdr_words = b[3:0];
		end else if (pos == eiuhp_pkg::PROTOCOL_POS) begin
			seen_protocol = b;
		end
		if (hdr_words >= eiuhp_pkg::MIN_IHL_WORDS && pos > eiuhp_pkg::ETH_HDR_BYTES) begin
			if (pos == udp_start + eiuhp_pkg::UDP_LEN_POS)
				seen_udp_len[15:8] = b;
			else if (pos == udp_start + eiuhp_pkg::UDP_LEN_POS + 1)
				seen_udp_len[7:0] = b;
		end
		frame_len = pos + 1;
		if (byte_cnt != 16'hFFFF)
			byte_cnt = byte_cnt + 16'd1;
		if (!fin)
			return;
		ip_bytes = 4 * hdr_words;
		v.status = eiuhp_pkg::ST_UDP_FOUND;
		v.payload_length = '0;
		v.payload_offset = '0;
		if (frame_len < eiuhp_pkg::ETH_HDR_BYTES)
			v.status = eiuhp_pkg::ST_SHORT_ETH;
		else if (seen_ethertype != want_ethertype)
			v.status = eiuhp_pkg::ST_ETHERTYPE;
		else if (frame_len < eiuhp_pkg::ETH_HDR_BYTES + eiuhp_pkg::IP_MIN_BYTES)
			v.status = eiuhp_pkg::ST_SHORT_IP;
		else if (seen_version != eiuhp_pkg::IPV4_VERSION)
			v.status = eiuhp_pkg::ST_VERSION;
		else if (seen_protocol != want_protocol)
			v.status = eiuhp_pkg::ST_PROTOCOL;
		else if (ip_bytes < eiuhp_pkg::IP_MIN_BYTES)
			v.status = eiuhp_pkg::ST_IHL;
		else if (eiuhp_pkg::ETH_HDR_BYTES + ip_bytes > frame_len)
			v.status = eiuhp_pkg::ST_OPTIONS;
		else if (eiuhp_pkg::ETH_HDR_BYTES + ip_bytes + eiuhp_pkg::UDP_HDR_BYTES > frame_len)
			v.status = eiuhp_pkg::ST_SHORT_UDP;
		else if (seen_udp_len < eiuhp_pkg::UDP_HDR_BYTES)
			v.status = eiuhp_pkg::ST_UDP_LEN;
		else begin
			v.payload_length = 16'(seen_udp_len - eiuhp_pkg::UDP_HDR_BYTES);
			v.payload_offset = 7'(eiuhp_pkg::ETH_HDR_BYTES + ip_bytes
				+ eiuhp_pkg::UDP_HDR_BYTES);
		end
		verdicts_due.push_back(v);
		byte_cnt = '0;
		seen_ethertype = '0;
		seen_version = '0;
		hdr_words = '0;
		seen_protocol = '0;
		seen_udp_len = '0;
	endfunction

	task report_mismatch(input string what, input int unsigned want, input int unsigned got);
		$display("%0t: mismatch in %s: expected %0d, got %0d", $time, what, want, got);
		mismatches++;
	endtask

	task cfg_write(input logic [eiuhp_pkg::CFG_INDEX_W-1:0] idx,
			input logic [eiuhp_pkg::CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		case (idx)
			eiuhp_pkg::CFG_EXPECTED_ETHERTYPE: want_ethertype = value;
			eiuhp_pkg::CFG_EXPECTED_PROTOCOL: want_protocol = value[7:0];
			default: ;
		endcase
	endtask

	task build_frame(input logic [15:0] etype, input logic [3:0] ver, input logic [3:0] ihl,
			input logic [7:0] proto, input logic [15:0] ulen, input int unsigned extra);
		int unsigned ip_len;
		ip_len = (ihl < eiuhp_pkg::MIN_IHL_WORDS) ? eiuhp_pkg::IP_MIN_BYTES : 4 * ihl;
		frame_buf.delete();
		repeat (eiuhp_pkg::ETHERTYPE_POS) frame_buf.push_back(8'($urandom));
		frame_buf.push_back(etype[15:8]);
		frame_buf.push_back(etype[7:0]);
		frame_buf.push_back({ver, ihl});
		while (frame_buf.size() < eiuhp_pkg::ETH_HDR_BYTES + ip_len
				+ eiuhp_pkg::UDP_HDR_BYTES + extra) begin
			if (frame_buf.size() == eiuhp_pkg::PROTOCOL_POS)
				frame_buf.push_back(proto);
			else if (frame_buf.size() == eiuhp_pkg::ETH_HDR_BYTES + ip_len
					+ eiuhp_pkg::UDP_LEN_POS)
				frame_buf.push_back(ulen[15:8]);
			else if (frame_buf.size() == eiuhp_pkg::ETH_HDR_BYTES + ip_len
					+ eiuhp_pkg::UDP_LEN_POS + 1)
				frame_buf.push_back(ulen[7:0]);
			else
				frame_buf.push_back(8'($urandom));
		end
	endtask

	task fill_frame(input int unsigned n, input logic [7:0] value, input bit scramble);
		frame_buf.delete();
		repeat (n) frame_buf.push_back(scramble ? 8'($urandom) : value);
	endtask

	task send_frame(input int unsigned n);
		frame_byte_t item;
		for (int unsigned i = 0; i < n; i++) begin
			item.data = frame_buf[i];
			item.fin = (i == n - 1);
			bytes_to_send.push_back(item);
		end
		bytes_queued += n;
	endtask

	task random_phase(input int unsigned min_bytes, input int unsigned min_frames);
		int unsigned start;
		int unsigned frames;
		int unsigned kind;
		logic [15:0] etype;
		logic [3:0]  ver;
		logic [3:0]  ihl;
		logic [7:0]  proto;
		logic [15:0] ulen;
		int unsigned extra;
		start = bytes_queued;
		frames = 0;
		while (bytes_queued - start < min_bytes || frames < min_frames) begin
			kind = $urandom_range(0, 15);
			etype = want_ethertype;
			ver = eiuhp_pkg::IPV4_VERSION;
			ihl = $urandom_range(0, 1) ? 4'(eiuhp_pkg::MIN_IHL_WORDS)
				: 4'($urandom_range(5, 15));
			proto = want_protocol;
			extra = $urandom_range(0, 8);
			case ($urandom_range(0, 3))
				0: ulen = 16'(eiuhp_pkg::UDP_HDR_BYTES + extra);
				1: ulen = 16'($urandom_range(0, 7));
				default: ulen = 16'($urandom);
			endcase
			if (kind >= 11 && kind <= 12) begin
				case ($urandom_range(0, 3))
					0: etype = 16'($urandom);
					1: ver = 4'($urandom);
					2: proto = 8'($urandom);
					default: ihl = 4'($urandom_range(0, 4));
				endcase
			end
			if (kind >= 13)
				fill_frame($urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(4, 100),
					8'd0, 1'b1);
			else
				build_frame(etype, ver, ihl, proto, ulen, extra);
			if (kind >= 9 && kind <= 10)
				send_frame($urandom_range(1, frame_buf.size()));
			else
				send_frame(frame_buf.size());
			frames++;
		end
	endtask

	task settle;
		while (bytes_to_send.size() != 0 || in_valid || verdicts_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		fill_frame(1, 8'h00, 1'b0);
		send_frame(1);
		fill_frame(1, 8'hFF, 1'b0);
		send_frame(1);
		build_frame(eiuhp_pkg::ETHERTYPE_IPV4, eiuhp_pkg::IPV4_VERSION, 4'd5,
			eiuhp_pkg::PROTO_UDP, 16'd8, 0);
		send_frame(13);
		send_frame(14);
		send_frame(33);
		send_frame(34);
		send_frame(41);
		send_frame(frame_buf.size());
		build_frame(16'h86DD, eiuhp_pkg::IPV4_VERSION, 4'd5, eiuhp_pkg::PROTO_UDP, 16'd8, 0);
		send_frame(frame_buf.size());
		build_frame(eiuhp_pkg::ETHERTYPE_IPV4, 4'd6, 4'd5, eiuhp_pkg::PROTO_UDP, 16'd8, 0);
		send_frame(frame_buf.size());
		build_frame(eiuhp_pkg::ETHERTYPE_IPV4, eiuhp_pkg::IPV4_VERSION, 4'd5, 8'd6, 16'd8, 0);
		send_frame(frame_buf.size());
		build_frame(eiuhp_pkg::ETHERTYPE_IPV4, eiuhp_pkg::IPV4_VERSION, 4'd0,
			eiuhp_pkg::PROTO_UDP, 16'd8, 0);
		send_frame(frame_buf.size());
		build_frame(eiuhp_pkg::ETHERTYPE_IPV4, eiuhp_pkg::IPV4_VERSION, 4'd4,
			eiuhp_pkg::PROTO_UDP, 16'd8, 0);
		send_frame(frame_buf.size());
		build_frame(eiuhp_pkg::ETHERTYPE_IPV4, eiuhp_pkg::IPV4_VERSION, 4'd6,
			eiuhp_pkg::PROTO_UDP, 16'd8, 0);
		send_frame(37);
		build_frame(eiuhp_pkg::ETHERTYPE_IPV4, eiuhp_pkg::IPV4_VERSION, 4'd5,
			eiuhp_pkg::PROTO_UDP, 16'd7, 0);
		send_frame(frame_buf.size());
		build_frame(eiuhp_pkg::ETHERTYPE_IPV4, eiuhp_pkg::IPV4_VERSION, 4'd5,
			eiuhp_pkg::PROTO_UDP, 16'd0, 3);
		send_frame(frame_buf.size());
		build_frame(eiuhp_pkg::ETHERTYPE_IPV4, eiuhp_pkg::IPV4_VERSION, 4'd5,
			eiuhp_pkg::PROTO_UDP, 16'hFFFF, 4);
		send_frame(frame_buf.size());
		build_frame(eiuhp_pkg::ETHERTYPE_IPV4, eiuhp_pkg::IPV4_VERSION, 4'd15,
			eiuhp_pkg::PROTO_UDP, 16'd20, 12);
		send_frame(frame_buf.size());
		fill_frame(60, 8'hFF, 1'b0);
		send_frame(60);
		fill_frame(60, 8'h00, 1'b0);
		send_frame(60);
		// Single-byte frames back to back force verdicts to queue up.
		repeat (4) begin
			fill_frame(1, 8'd0, 1'b1);
			send_frame(1);
		end
		settle();

		cfg_write(eiuhp_pkg::CFG_EXPECTED_ETHERTYPE, 16'hFFFF);
		cfg_write(eiuhp_pkg::CFG_EXPECTED_PROTOCOL, 16'h00FF);
		cfg_write(CFG_UNMAPPED_A, 16'($urandom));
		cfg_write(CFG_UNMAPPED_B, 16'($urandom));
		@(negedge clk);
		random_phase(160, 4);
		settle();

		cfg_write(eiuhp_pkg::CFG_EXPECTED_ETHERTYPE, 16'h0000);
		cfg_write(eiuhp_pkg::CFG_EXPECTED_PROTOCOL, 16'h0000);
		@(negedge clk);
		random_phase(160, 4);
		settle();

		cfg_write(eiuhp_pkg::CFG_EXPECTED_ETHERTYPE, 16'($urandom));
		cfg_write(eiuhp_pkg::CFG_EXPECTED_PROTOCOL, 16'($urandom));
		@(negedge clk);
		random_phase(160, 4);
		settle();

		cfg_write(eiuhp_pkg::CFG_EXPECTED_PROTOCOL, {8'($urandom), eiuhp_pkg::PROTO_UDP});
		cfg_write(eiuhp_pkg::CFG_EXPECTED_ETHERTYPE, eiuhp_pkg::ETHERTYPE_IPV4);
		@(negedge clk);
		random_phase(160, 4);
		settle();

		if (verdicts_due.size() != 0)
			report_mismatch("verdicts still due", 0, verdicts_due.size());
		if (mismatches == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				parse_byte(data_byte, last_byte);
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (bytes_to_send.size() != 0) begin
					next_byte = bytes_to_send.pop_front();
					in_valid <= 1'b1;
					data_byte <= next_byte.data;
					last_byte <= next_byte.fin;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 48);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			rx_cycle++;
			if (rx_cycle % 256 == 0)
				rx_pattern = rx_pattern_t'($urandom_range(0, 2));
			if (stall_left != 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (rx_pattern == RX_CHOPPY && $urandom_range(0, 1) == 1) begin
				out_stall <= 1'b1;
			end else if (rx_pattern == RX_BURSTY && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				stall_left = $urandom_range(1, 11);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (verdicts_due.size() == 0) begin
				report_mismatch("verdict with none due", 0, status);
			end else begin
				due = verdicts_due.pop_front();
				if (status !== due.status)
					report_mismatch("status", due.status, status);
				if (payload_length !== due.payload_length)
					report_mismatch("payload_length", due.payload_length, payload_length);
				if (payload_offset !== due.payload_offset)
					report_mismatch("payload_offset", due.payload_offset, payload_offset);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no item accepted for %0d cycles", $time, IDLE_LIMIT);
				$display("tb NOT OK");
				$finish;
			end
		end
	end
endmodule
